@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the machine core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bfm_pkg.sv @@
// ----------------------------------------------------------------------------
// bfm_pkg
// Types and constants shared by the machine core and its interfaces.
// ----------------------------------------------------------------------------
`default_nettype none
package bfm_pkg;
    localparam int PROG_DEPTH_DEF  = 4096;
    localparam int TAPE_DEPTH_DEF  = 16384;
    localparam int STACK_DEPTH_DEF = 256;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_EXECUTED = 3'd1,
        ST_WAITING  = 3'd2,
        ST_HALTED   = 3'd3,
        ST_BRACKET  = 3'd4,
        ST_RANGE    = 3'd5,
        ST_FULL     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD2,
        S_EXEC,
        S_OUT
    } fsm_t;

    localparam logic [7:0] SYM_INC   = 8'h2B;
    localparam logic [7:0] SYM_DEC   = 8'h2D;
    localparam logic [7:0] SYM_RIGHT = 8'h3E;
    localparam logic [7:0] SYM_LEFT  = 8'h3C;
    localparam logic [7:0] SYM_OPEN  = 8'h5B;
    localparam logic [7:0] SYM_CLOSE = 8'h5D;
    localparam logic [7:0] SYM_OUT   = 8'h2E;
    localparam logic [7:0] SYM_IN    = 8'h2C;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] symbol;
        logic [7:0] input_byte;
        logic       input_present;
        logic       input_eof;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        input_taken;
        logic [12:0] instr_index;
        logic [14:0] cells_used;
    } out_item_t;
endpackage
`default_nettype wire

@@ hdl/bfm_in_if.sv @@
// ----------------------------------------------------------------------------
// bfm_in_if
// Command channel: valid, ready and one command beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface bfm_in_if;
    logic               valid;
    logic               ready;
    bfm_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/bfm_out_if.sv @@
// ----------------------------------------------------------------------------
// bfm_out_if
// Result channel: valid, ready and one result beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface bfm_out_if;
    logic               valid;
    logic               ready;
    bfm_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/bfm_ram.sv @@
// ----------------------------------------------------------------------------
// bfm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/brainfuck_machine_core.sv @@
// ----------------------------------------------------------------------------
// brainfuck_machine_core
// Command-driven interpreter with 8-bit cells; one result beat per command.
// ----------------------------------------------------------------------------
// Every command passes through acceptance (S_IDLE), a state (S_EXEC) in
// which the program, jump table, bracket stack or tape memory returns its
// registered read data and the result is formed, and a hand-off state (S_OUT)
// that moves the result to the output register; a closing bracket on load
// adds a state (S_LOAD2) to write the second jump-table entry. After reset and
// after each start command the tape is cleared one cell a cycle, and no
// command is accepted while it is cleared. The next command is accepted while
// a result waits in the output register, but its own result is held in the
// hand-off state until the waiting beat has been taken.
`default_nettype none
`include "assert_macros.svh"
module brainfuck_machine_core #(
    parameter int PROG_DEPTH  = bfm_pkg::PROG_DEPTH_DEF,
    parameter int TAPE_DEPTH  = bfm_pkg::TAPE_DEPTH_DEF,
    parameter int STACK_DEPTH = bfm_pkg::STACK_DEPTH_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    bfm_in_if.sink    in_ch,
    bfm_out_if.source out_ch
);
    localparam int PW = $clog2(PROG_DEPTH);
    localparam int TW = $clog2(TAPE_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH);

    bfm_pkg::fsm_t state_reg, state_next;

    logic [PW:0]   plen_reg, plen_next;
    logic [PW:0]   ip_reg, ip_next;
    logic [SW:0]   sc_reg, sc_next;
    logic [TW-1:0] dp_reg, dp_next;
    logic [TW-1:0] maxp_reg, maxp_next;
    logic          fault_reg, fault_next;
    logic          halt_reg, halt_next;
    logic [TW-1:0] clr_reg, clr_next;
    logic [PW-1:0] pos_reg, pos_next;
    bfm_pkg::in_item_t  cmd_reg, cmd_next;
    bfm_pkg::out_item_t res_reg, res_next;
    bfm_pkg::out_item_t pend_reg, pend_next;
    logic          ovalid_reg, ovalid_next;

    // memory ports
    logic          prog_we;
    logic [PW-1:0] prog_wa, prog_ra;
    logic [7:0]    prog_wd, prog_rd;
    logic          jt_we;
    logic [PW-1:0] jt_wa, jt_ra;
    logic [PW-1:0] jt_wd, jt_rd;
    logic          stk_we;
    logic [SW-1:0] stk_wa, stk_ra;
    logic [PW-1:0] stk_wd, stk_rd;
    logic          tp_we;
    logic [TW-1:0] tp_wa, tp_ra;
    logic [7:0]    tp_wd, tp_rd;

    bfm_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
        .clk(clk), .we(prog_we), .waddr(prog_wa), .wdata(prog_wd),
        .raddr(prog_ra), .rdata(prog_rd));
    bfm_ram #(.WIDTH(PW), .DEPTH(PROG_DEPTH)) u_jump (
        .clk(clk), .we(jt_we), .waddr(jt_wa), .wdata(jt_wd),
        .raddr(jt_ra), .rdata(jt_rd));
    bfm_ram #(.WIDTH(PW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
        .raddr(stk_ra), .rdata(stk_rd));
    bfm_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
        .clk(clk), .we(tp_we), .waddr(tp_wa), .wdata(tp_wd),
        .raddr(tp_ra), .rdata(tp_rd));

    logic in_fire, out_free;
    assign out_free     = !ovalid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == bfm_pkg::S_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bfm_pkg::S_CLEAR;
            plen_reg   <= '0;
            ip_reg     <= '0;
            sc_reg     <= '0;
            dp_reg     <= '0;
            maxp_reg   <= '0;
            fault_reg  <= 1'b0;
            halt_reg   <= 1'b0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            plen_reg   <= plen_next;
            ip_reg     <= ip_next;
            sc_reg     <= sc_next;
            dp_reg     <= dp_next;
            maxp_reg   <= maxp_next;
            fault_reg  <= fault_next;
            halt_reg   <= halt_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        res_reg  <= res_next;
        pend_reg <= pend_next;
        pos_reg  <= pos_next;
    end

    logic [PW:0] ip_inc;
    logic [7:0]  cell_val;
    logic [2:0]  st;
    logic        ov, it;
    logic [7:0]  ob;

    always_comb
    begin
        state_next  = state_reg;
        plen_next   = plen_reg;
        ip_next     = ip_reg;
        sc_next     = sc_reg;
        dp_next     = dp_reg;
        maxp_next   = maxp_reg;
        fault_next  = fault_reg;
        halt_next   = halt_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        res_next    = res_reg;
        pend_next   = pend_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        prog_we = 1'b0; prog_wa = plen_reg[PW-1:0]; prog_wd = cmd_reg.symbol;
        prog_ra = ip_reg[PW-1:0];
        jt_we = 1'b0; jt_wa = '0; jt_wd = '0; jt_ra = ip_reg[PW-1:0];
        stk_we = 1'b0; stk_wa = sc_reg[SW-1:0]; stk_wd = plen_reg[PW-1:0];
        stk_ra = sc_reg[SW-1:0] - 1'b1;
        tp_we = 1'b0; tp_wa = dp_reg; tp_wd = '0; tp_ra = dp_reg;
        ip_inc = ip_reg + 1'b1;
        cell_val = tp_rd;
        st = bfm_pkg::ST_ACCEPTED;
        ov = 1'b0; ob = '0; it = 1'b0;

        unique case (state_reg)
            bfm_pkg::S_CLEAR:
            begin
                tp_we = 1'b1;
                tp_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TW'(TAPE_DEPTH - 1))
                begin
                    clr_next   = '0;
                    state_next = bfm_pkg::S_IDLE;
                end
            end
            bfm_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = in_ch.data;
                    state_next = bfm_pkg::S_EXEC;
                end
            end
            bfm_pkg::S_EXEC:
            begin
                // memory read data for the accepted command is valid here
                state_next = bfm_pkg::S_OUT;
                if (cmd_reg.command == bfm_pkg::CMD_START)
                begin
                    plen_next = '0; ip_next = '0; sc_next = '0; dp_next = '0;
                    maxp_next = '0; fault_next = 1'b0; halt_next = 1'b0;
                end
                else if (cmd_reg.command == bfm_pkg::CMD_LOAD)
                begin
                    if (plen_reg >= (PW+1)'(PROG_DEPTH))
                    begin
                        st = bfm_pkg::ST_FULL;
                    end
                    else
                    begin
                        prog_we   = 1'b1;
                        plen_next = plen_reg + 1'b1;
                        if (cmd_reg.symbol == bfm_pkg::SYM_OPEN)
                        begin
                            if (sc_reg >= (SW+1)'(STACK_DEPTH))
                            begin
                                fault_next = 1'b1;
                                st = bfm_pkg::ST_BRACKET;
                            end
                            else
                            begin
                                stk_we  = 1'b1;
                                sc_next = sc_reg + 1'b1;
                            end
                        end
                        else if (cmd_reg.symbol == bfm_pkg::SYM_CLOSE)
                        begin
                            if (sc_reg == '0)
                            begin
                                fault_next = 1'b1;
                                st = bfm_pkg::ST_BRACKET;
                            end
                            else
                            begin
                                sc_next = sc_reg - 1'b1;
                                jt_we = 1'b1;
                                jt_wa = plen_reg[PW-1:0];
                                jt_wd = stk_rd;
                                pos_next = plen_reg[PW-1:0];
                                state_next = bfm_pkg::S_LOAD2;
                            end
                        end
                    end
                end
                else if (cmd_reg.command == bfm_pkg::CMD_STEP)
                begin
                    if (fault_reg || sc_reg != '0)
                        st = bfm_pkg::ST_BRACKET;
                    else if (halt_reg)
                        st = bfm_pkg::ST_HALTED;
                    else if (ip_reg >= plen_reg)
                    begin
                        halt_next = 1'b1;
                        st = bfm_pkg::ST_HALTED;
                    end
                    else
                    begin
                        st = bfm_pkg::ST_EXECUTED;
                        unique case (prog_rd)
                            bfm_pkg::SYM_RIGHT:
                                if (dp_reg == TW'(TAPE_DEPTH - 1))
                                    st = bfm_pkg::ST_RANGE;
                                else
                                begin
                                    dp_next = dp_reg + 1'b1;
                                    if (dp_next > maxp_reg)
                                        maxp_next = dp_next;
                                    ip_next = ip_inc;
                                end
                            bfm_pkg::SYM_LEFT:
                                if (dp_reg == '0)
                                    st = bfm_pkg::ST_RANGE;
                                else
                                begin
                                    dp_next = dp_reg - 1'b1;
                                    ip_next = ip_inc;
                                end
                            bfm_pkg::SYM_INC:
                            begin
                                tp_we = 1'b1; tp_wd = cell_val + 8'd1; ip_next = ip_inc;
                            end
                            bfm_pkg::SYM_DEC:
                            begin
                                tp_we = 1'b1; tp_wd = cell_val - 8'd1; ip_next = ip_inc;
                            end
                            bfm_pkg::SYM_OPEN:
                                ip_next = (cell_val == 8'd0) ? {1'b0, jt_rd} + 1'b1 : ip_inc;
                            bfm_pkg::SYM_CLOSE:
                                ip_next = (cell_val != 8'd0) ? {1'b0, jt_rd} + 1'b1 : ip_inc;
                            bfm_pkg::SYM_OUT:
                            begin
                                ov = 1'b1; ob = cell_val; ip_next = ip_inc;
                            end
                            bfm_pkg::SYM_IN:
                                if (cmd_reg.input_present || cmd_reg.input_eof)
                                begin
                                    tp_we = 1'b1;
                                    tp_wd = cmd_reg.input_present ? cmd_reg.input_byte : 8'd0;
                                    it = 1'b1;
                                    ip_next = ip_inc;
                                end
                                else
                                    st = bfm_pkg::ST_WAITING;
                            default:
                            begin
                                ip_next = plen_reg;
                                halt_next = 1'b1;
                                st = bfm_pkg::ST_HALTED;
                            end
                        endcase
                    end
                end
                // held here until the output register is free
                pend_next.status      = st;
                pend_next.out_valid   = ov;
                pend_next.out_byte    = ob;
                pend_next.input_taken = it;
                pend_next.instr_index = 13'(ip_next);
                pend_next.cells_used  = 15'(maxp_next) + 15'd1;
            end
            bfm_pkg::S_LOAD2:
            begin
                // second jump entry: opener points at the closer
                jt_we = 1'b1;
                jt_wa = stk_rd;
                jt_wd = pos_reg;
                stk_ra = sc_reg[SW-1:0];
                state_next = bfm_pkg::S_OUT;
            end
            bfm_pkg::S_OUT:
            begin
                stk_ra = sc_reg[SW-1:0];
                if (out_free)
                begin
                    res_next    = pend_reg;
                    ovalid_next = 1'b1;
                    state_next = (cmd_reg.command == bfm_pkg::CMD_START) ?
                                 bfm_pkg::S_CLEAR : bfm_pkg::S_IDLE;
                end
            end
            default:
                state_next = bfm_pkg::S_IDLE;
        endcase
    end

    // second jump-table write always hands over to the output stage
    `ASSERT_NEXT(a_load2_from_exec, state_reg == bfm_pkg::S_LOAD2,
        state_reg == bfm_pkg::S_OUT, "load2 must go to output")
    `ASSERT_IMPL(a_no_accept_clear, state_reg == bfm_pkg::S_CLEAR,
        !in_ch.ready, "command accepted during tape clear")
    `ASSERT_IMPL(a_ip_bound, state_reg == bfm_pkg::S_IDLE,
        ip_reg <= plen_reg || halt_reg || fault_reg || sc_reg != '0,
        "instruction pointer beyond program")
endmodule
`default_nettype wire

@@ verif/tb_brainfuck_machine_core.sv @@
// ----------------------------------------------------------------------------
// tb_brainfuck_machine_core
// Self-checking bench: commands driven over valid/ready, each result beat
// checked field by field against a behavioural machine kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_brainfuck_machine_core;

    localparam int PDEP = bfm_pkg::PROG_DEPTH_DEF;
    localparam int TDEP = bfm_pkg::TAPE_DEPTH_DEF;
    localparam int SDEP = bfm_pkg::STACK_DEPTH_DEF;

    logic clk;
    logic rst_n;
    bfm_in_if  in_ch();
    bfm_out_if out_ch();

    brainfuck_machine_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // machine state mirrored in the bench
    logic [7:0]  prog_mem [PDEP];
    logic [11:0] jump_mem [PDEP];
    logic [11:0] open_mem [SDEP];
    logic [7:0]  cell_mem [TDEP];
    int unsigned open_cnt, prog_len, ip, dp, dp_max;
    bit          br_fault, halted;

    bfm_pkg::out_item_t expected_q[$];
    int          fail_cnt;
    int          beats_sent, beats_seen, out_chars, step_cnt;
    int          send_idle_pct, recv_stall_pct;
    bit          hold_off;
    bit          valid_drv;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void clear_machine();
        open_cnt = 0; prog_len = 0; ip = 0; dp = 0; dp_max = 0;
        br_fault = 0; halted = 0;
        foreach (cell_mem[i]) cell_mem[i] = 8'd0;
    endfunction

    function automatic logic [2:0] load_symbol(logic [7:0] sym);
        int unsigned pos, op;
        if (prog_len >= PDEP) return bfm_pkg::ST_FULL;
        pos = prog_len;
        prog_mem[pos] = sym;
        prog_len = pos + 1;
        if (sym == bfm_pkg::SYM_OPEN) begin
            if (open_cnt >= SDEP) begin
                br_fault = 1;
                return bfm_pkg::ST_BRACKET;
            end
            open_mem[open_cnt] = pos[11:0];
            open_cnt++;
        end
        else if (sym == bfm_pkg::SYM_CLOSE) begin
            if (open_cnt == 0) begin
                br_fault = 1;
                return bfm_pkg::ST_BRACKET;
            end
            open_cnt--;
            op = open_mem[open_cnt];
            jump_mem[op]  = pos[11:0];
            jump_mem[pos] = op[11:0];
        end
        return bfm_pkg::ST_ACCEPTED;
    endfunction

    function automatic logic [2:0] exec_instr(bfm_pkg::in_item_t it,
                                              ref bfm_pkg::out_item_t r);
        logic [7:0] c;
        if (br_fault || open_cnt != 0) return bfm_pkg::ST_BRACKET;
        if (halted) return bfm_pkg::ST_HALTED;
        if (ip >= prog_len || ip >= PDEP) begin
            halted = 1;
            return bfm_pkg::ST_HALTED;
        end
        c = cell_mem[dp];
        case (prog_mem[ip])
            bfm_pkg::SYM_RIGHT: begin
                if (dp + 1 >= TDEP) return bfm_pkg::ST_RANGE;
                dp++;
                if (dp > dp_max) dp_max = dp;
                ip++;
            end
            bfm_pkg::SYM_LEFT: begin
                if (dp == 0) return bfm_pkg::ST_RANGE;
                dp--;
                ip++;
            end
            bfm_pkg::SYM_INC: begin cell_mem[dp] = c + 8'd1; ip++; end
            bfm_pkg::SYM_DEC: begin cell_mem[dp] = c - 8'd1; ip++; end
            bfm_pkg::SYM_OPEN:  ip = (c == 0) ? jump_mem[ip] + 1 : ip + 1;
            bfm_pkg::SYM_CLOSE: ip = (c != 0) ? jump_mem[ip] + 1 : ip + 1;
            bfm_pkg::SYM_OUT: begin
                r.out_valid = 1'b1;
                r.out_byte  = c;
                out_chars++;
                ip++;
            end
            bfm_pkg::SYM_IN: begin
                if (it.input_present) cell_mem[dp] = it.input_byte;
                else if (it.input_eof) cell_mem[dp] = 8'd0;
                else return bfm_pkg::ST_WAITING;
                r.input_taken = 1'b1;
                ip++;
            end
            default: begin
                ip = prog_len;
                halted = 1;
                return bfm_pkg::ST_HALTED;
            end
        endcase
        return bfm_pkg::ST_EXECUTED;
    endfunction

    function automatic bfm_pkg::out_item_t predict_result(bfm_pkg::in_item_t it);
        bfm_pkg::out_item_t r;
        r = '0;
        r.status = bfm_pkg::ST_ACCEPTED;
        case (it.command)
            bfm_pkg::CMD_START: clear_machine();
            bfm_pkg::CMD_LOAD:  r.status = load_symbol(it.symbol);
            bfm_pkg::CMD_STEP:  begin r.status = exec_instr(it, r); step_cnt++; end
            default: ;
        endcase
        r.instr_index = ip[12:0];
        r.cells_used  = 15'(dp_max + 1);
        return r;
    endfunction

    // drop valid once, only if it is currently being driven high
    task automatic release_bus();
        if (valid_drv) begin
            in_ch.valid <= 1'b0;
            valid_drv = 1'b0;
        end
    endtask

    task automatic send_beat(bfm_pkg::in_item_t it);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            release_bus();
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        valid_drv = 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        expected_q.push_back(predict_result(it));
        beats_sent++;
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic [7:0] sym = 8'd0,
                            logic [7:0] ib = 8'd0, bit pres = 0, bit eof = 0);
        bfm_pkg::in_item_t it;
        it.command = cmd;
        it.symbol = sym;
        it.input_byte = ib;
        it.input_present = pres;
        it.input_eof = eof;
        send_beat(it);
    endtask

    task automatic load_text(string s);
        for (int i = 0; i < s.len(); i++) send_cmd(bfm_pkg::CMD_LOAD, s[i]);
    endtask

    task automatic drain();
        int n;
        n = 0;
        release_bus();
        while (expected_q.size() != 0 && n < 200000) begin
            @(posedge clk);
            n++;
        end
    endtask

    // receiver side: random stalls, plus a long hold-off when asked
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !(recv_stall_pct > 0 &&
                              $urandom_range(99, 0) < recv_stall_pct);
    end

    always @(posedge clk) begin
        bfm_pkg::out_item_t e, a;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            beats_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat %p", $realtime, a);
                fail_cnt++;
            end
            else begin
                e = expected_q.pop_front();
                if (a.status !== e.status || a.out_valid !== e.out_valid ||
                    a.out_byte !== e.out_byte || a.input_taken !== e.input_taken ||
                    a.instr_index !== e.instr_index || a.cells_used !== e.cells_used)
                begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, e, a);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        send_cmd(bfm_pkg::CMD_RSVD, 8'hFF, 8'hFF, 1, 1);  // unknown command
        send_cmd(bfm_pkg::CMD_STEP);                      // empty program halts
        send_cmd(bfm_pkg::CMD_START);
        load_text("<+-[.],x");
        for (int i = 0; i < 5; i++) send_cmd(bfm_pkg::CMD_STEP); // off the left end
        send_cmd(bfm_pkg::CMD_START);
        load_text("-.,,,.>+.x");
        send_cmd(bfm_pkg::CMD_STEP);
        send_cmd(bfm_pkg::CMD_STEP);
        send_cmd(bfm_pkg::CMD_STEP);                       // no input yet: waiting
        send_cmd(bfm_pkg::CMD_STEP, 8'd0, 8'hA5, 1, 1);    // present wins over eof
        send_cmd(bfm_pkg::CMD_STEP, 8'd0, 8'h5A, 0, 1);    // eof stores zero
        send_cmd(bfm_pkg::CMD_STEP, 8'd0, 8'hFF, 1, 0);
        for (int i = 0; i < 6; i++) send_cmd(bfm_pkg::CMD_STEP);
        send_cmd(bfm_pkg::CMD_LOAD, bfm_pkg::SYM_INC);     // reload after halt
        send_cmd(bfm_pkg::CMD_STEP);
        send_cmd(bfm_pkg::CMD_START);
        load_text("]+");                                   // unmatched close
        send_cmd(bfm_pkg::CMD_STEP);
        send_cmd(bfm_pkg::CMD_START);
        load_text("[[+");                                  // open left on stack
        send_cmd(bfm_pkg::CMD_STEP);
    endtask

    // loops, nested brackets, moves and I/O with random content
    task automatic run_random_program(int steps);
        int len, depth;
        string s;
        byte sym;
        send_cmd(bfm_pkg::CMD_START);
        s = "";
        depth = 0;
        len = $urandom_range(20, 2);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(11, 0))
                0, 1: sym = bfm_pkg::SYM_INC;
                2:    sym = bfm_pkg::SYM_DEC;
                3:    sym = bfm_pkg::SYM_RIGHT;
                4:    sym = bfm_pkg::SYM_LEFT;
                5:    sym = bfm_pkg::SYM_OUT;
                6:    sym = bfm_pkg::SYM_IN;
                7:    begin sym = bfm_pkg::SYM_OPEN; depth++; end
                8:    sym = depth > 0 ? bfm_pkg::SYM_CLOSE : bfm_pkg::SYM_INC;
                9:    sym = bfm_pkg::SYM_DEC;
                10:   sym = ($urandom_range(9, 0) == 0) ? byte'($urandom) :
                            bfm_pkg::SYM_RIGHT;
                default: sym = bfm_pkg::SYM_OUT;
            endcase
            if (sym == bfm_pkg::SYM_CLOSE) depth--;
            s = {s, string'(sym)};
        end
        if ($urandom_range(9, 0) != 0)
            while (depth > 0) begin s = {s, "]"}; depth--; end
        load_text(s);
        for (int i = 0; i < steps; i++)
            send_cmd($urandom_range(19, 0) == 0 ? 2'($urandom_range(3, 1)) :
                     bfm_pkg::CMD_STEP,
                     8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic test_random(int idle, int stall, int count);
        int goal;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        goal = beats_sent + count;
        while (beats_sent < goal) run_random_program($urandom_range(30, 5));
        drain();
    endtask

    task automatic test_stack_overflow();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_cmd(bfm_pkg::CMD_START);
        // nested opens beyond the bracket stack
        for (int i = 0; i < SDEP + 2; i++)
            send_cmd(bfm_pkg::CMD_LOAD, bfm_pkg::SYM_OPEN);
        send_cmd(bfm_pkg::CMD_STEP);
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                send_cmd(bfm_pkg::CMD_START);
                load_text("+++.>-.");
                for (int i = 0; i < 8; i++) send_cmd(bfm_pkg::CMD_STEP);
                release_bus();
            end
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        valid_drv = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_cnt = 0; beats_sent = 0; beats_seen = 0; out_chars = 0; step_cnt = 0;
        foreach (prog_mem[i]) prog_mem[i] = 8'd0;
        foreach (jump_mem[i]) jump_mem[i] = 12'd0;
        foreach (open_mem[i]) open_mem[i] = 12'd0;
        clear_machine();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        test_backpressure();
        test_random(0, 0, 160);
        test_random(79, 0, 160);
        test_random(0, 79, 160);
        test_random(38, 38, 160);
        test_stack_overflow();
        repeat (50) @(posedge clk);
        $display("%0d commands sent, %0d results checked, %0d steps, %0d output bytes",
                 beats_sent, beats_seen, step_cnt, out_chars);
        $display("covered: corner cases, long output hold-off, four idle/stall mixes, "
                 , "bracket stack overflow");
        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, expected_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
